### rtl/assert_macros.svh
// Assertion helpers for the RTL. Both expect clk_i in scope; ASSERT_RST also expects rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checked outside reset only.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked at every edge, reset included.
`define ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ASSERT_RST(lbl, prop, msg)
`define ASSERT_ALL(lbl, prop, msg)
`endif
`endif

### rtl/slst_pkg.sv
`default_nettype none
package slst_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned LEN_W    = ADDR_W + 1;

  typedef enum logic [3:0] {
    OP_APPEND  = 4'd0,
    OP_INSERT  = 4'd1,
    OP_GET     = 4'd2,
    OP_REPLACE = 4'd3,
    OP_REMOVE  = 4'd4,
    OP_POP     = 4'd5,
    OP_TAIL    = 4'd6,
    OP_TRUNC   = 4'd7,
    OP_COUNT   = 4'd8,
    OP_SUM     = 4'd9,
    OP_MEAN    = 4'd10,
    OP_POPVAR  = 4'd11,
    OP_SMPVAR  = 4'd12,
    OP_POPSTD  = 4'd13,
    OP_SMPSTD  = 4'd14
  } op_e;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_RANGE  = 3'd1,
    ERR_EMPTY  = 3'd2,
    ERR_NAN    = 3'd3,
    ERR_SINGLE = 3'd4,
    ERR_FULL   = 3'd5
  } err_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_SH_RD,
    S_SH_WR,
    S_INS_WR,
    S_SUM,
    S_DIV,
    S_DEV,
    S_SQRT,
    S_DONE
  } state_e;

endpackage
`default_nettype wire

### rtl/sample_list_statistics_top.sv
// Channel | Handshake              | Payload
// input   | in_valid_i/in_ready_o  | operation, position, append_at_end, sample_value,
//         |                        | value_is_nan, skip_count, max_count, new_length
// output  | out_valid_o/out_ready_i| result_value, result_is_nan, range_count, error_code
//
// One item at a time; the sample memory (one read and one write port, registered read)
// sets the pace. Insert and remove move the shifted entries one at a time. Sum reads
// the range once; mean adds a restoring divide; variance reads it again and divides
// again; deviation adds a 32-step root. Reset empties the list at once, no clearing pass.
// A finished result waits in the output register while the next item is accepted.
`default_nettype none
`include "assert_macros.svh"
module sample_list_statistics_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [3:0]                  operation_i,
  input  wire logic [9:0]                  position_i,
  input  wire logic                        append_at_end_i,
  input  wire logic signed [31:0]          sample_value_i,
  input  wire logic                        value_is_nan_i,
  input  wire logic [slst_pkg::LEN_W-1:0]  skip_count_i,
  input  wire logic [slst_pkg::LEN_W-1:0]  max_count_i,
  input  wire logic [slst_pkg::LEN_W-1:0]  new_length_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic signed [63:0]               result_value_o,
  output logic                             result_is_nan_o,
  output logic [slst_pkg::LEN_W-1:0]       range_count_o,
  output logic [2:0]                       error_code_o
);
  import slst_pkg::*;

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic end_q, end_d, nan_q, nan_d;
  logic [31:0] val_q, val_d;
  logic [LEN_W-1:0] len_q, len_d, start_q, start_d, n_q, n_d, nl_q, nl_d;
  logic [LEN_W-1:0] idx_q, idx_d, rdc_q, rdc_d;
  logic ins_q, ins_d, v1_q, v1_d, v2_q, v2_d, mph_q, mph_d, neg_q, neg_d, big_q, big_d;
  logic signed [42:0] sum_q, sum_d;
  logic signed [32:0] mean_q, mean_d;
  logic [75:0] acc_q, acc_d;
  logic [65:0] sq_q, sq_d;
  logic [63:0] dq_q, dq_d, sx_q, sx_d, sr_q, sr_d, sb_q, sb_d, res_q, res_d;
  logic [ADDR_W:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [5:0] cnt_q, cnt_d;
  logic rnan_q, rnan_d;
  logic [LEN_W-1:0] rcnt_q, rcnt_d;
  err_e err_q, err_d;
  logic load_out;
  logic ov_q, ov_d;

  logic we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [31:0] wdata, rdata;

  logic [LEN_W-1:0] in_start, in_avail, in_n;
  logic [ADDR_W+1:0] div_t;
  logic div_ge;
  logic [63:0] dq_nx, q_abs, sq_sum, sr_nx;
  logic sq_ge;
  logic signed [33:0] dev;
  logic [32:0] dev_abs;
  logic [42:0] sum_abs;
  logic [LEN_W-1:0] rd_addr;

  slst_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Range selection from the live inputs; the length is stable while idle.
  assign in_start = (skip_count_i < len_q) ? skip_count_i : len_q;
  assign in_avail = len_q - in_start;
  assign in_n     = (max_count_i < in_avail) ? max_count_i : in_avail;

  assign div_t  = {rem_q, dq_q[63]};
  assign div_ge = div_t >= {1'b0, dvs_q};
  assign dq_nx  = {dq_q[62:0], div_ge};
  assign q_abs  = neg_q ? (64'd0 - dq_nx) : dq_nx;

  assign sq_sum = sr_q + sb_q;
  assign sq_ge  = sx_q >= sq_sum;
  assign sr_nx  = sq_ge ? ((sr_q >> 1) + sb_q) : (sr_q >> 1);

  assign dev     = $signed({{2{rdata[31]}}, rdata}) - $signed({mean_q[32], mean_q});
  assign dev_abs = dev[33] ? 33'(-dev) : dev[32:0];
  assign sum_abs = sum_q[42] ? 43'(-sum_q) : sum_q;
  assign rd_addr = start_q + rdc_q;

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      v1_q    <= v1_d;
      v2_q    <= v2_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;   pos_q <= pos_d;   end_q <= end_d;   nan_q <= nan_d;
    val_q <= val_d; start_q <= start_d; n_q <= n_d;     nl_q <= nl_d;
    idx_q <= idx_d; rdc_q <= rdc_d;   ins_q <= ins_d;   mph_q <= mph_d;
    neg_q <= neg_d; big_q <= big_d;   sum_q <= sum_d;   mean_q <= mean_d;
    acc_q <= acc_d; sq_q <= sq_d;     dq_q <= dq_d;     sx_q <= sx_d;
    sr_q <= sr_d;   sb_q <= sb_d;     res_q <= res_d;   rem_q <= rem_d;
    dvs_q <= dvs_d; cnt_q <= cnt_d;   rnan_q <= rnan_d; rcnt_q <= rcnt_d;
    err_q <= err_d;
    if (load_out) begin
      result_value_o  <= res_q;
      result_is_nan_o <= rnan_q;
      range_count_o   <= rcnt_q;
      error_code_o    <= err_q;
    end
  end

  assign out_valid_o = ov_q;

  always_comb begin
    state_d = state_q;
    op_d = op_q;   pos_d = pos_q;   end_d = end_q;   nan_d = nan_q;
    val_d = val_q; start_d = start_q; n_d = n_q;     nl_d = nl_q;
    idx_d = idx_q; rdc_d = rdc_q;   ins_d = ins_q;   mph_d = mph_q;
    neg_d = neg_q; big_d = big_q;   sum_d = sum_q;   mean_d = mean_q;
    acc_d = acc_q; sq_d = sq_q;     dq_d = dq_q;     sx_d = sx_q;
    sr_d = sr_q;   sb_d = sb_q;     res_d = res_q;   rem_d = rem_q;
    dvs_d = dvs_q; cnt_d = cnt_q;   rnan_d = rnan_q; rcnt_d = rcnt_q;
    err_d = err_q; len_d = len_q;
    v1_d = 1'b0;   v2_d = 1'b0;
    we = 1'b0;     waddr = pos_q;   wdata = val_q;   raddr = pos_q;
    load_out = 1'b0;
    ov_d = ov_q && !out_ready_i;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = op_e'(operation_i);
          pos_d   = position_i;
          end_d   = append_at_end_i;
          nan_d   = value_is_nan_i;
          val_d   = value_is_nan_i ? 32'd0 : sample_value_i;
          start_d = in_start;
          n_d     = in_n;
          nl_d    = new_length_i;
          res_d   = '0;
          rnan_d  = 1'b0;
          rcnt_d  = '0;
          err_d   = ERR_NONE;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_DONE;
        case (op_q)
          OP_APPEND, OP_INSERT: begin
            if (op_q == OP_INSERT && !end_q && len_q != '0) begin
              if ({1'b0, pos_q} > len_q) begin
                err_d = ERR_RANGE;
              end else if (len_q >= LEN_W'(CAPACITY)) begin
                err_d = ERR_FULL;
              end else begin
                idx_d   = len_q;
                ins_d   = 1'b1;
                state_d = (len_q > {1'b0, pos_q}) ? S_SH_RD : S_INS_WR;
              end
            end else if (op_q == OP_INSERT && !end_q && pos_q != '0) begin
              err_d = ERR_RANGE;
            end else if (len_q >= LEN_W'(CAPACITY)) begin
              err_d = ERR_FULL;
            end else begin
              // Append; an insert that appends drops the NaN error.
              we    = 1'b1;
              waddr = len_q[ADDR_W-1:0];
              len_d = len_q + 1'b1;
              res_d = {{32{val_q[31]}}, val_q};
              err_d = (nan_q && op_q == OP_APPEND) ? ERR_NAN : ERR_NONE;
            end
          end
          OP_GET, OP_REPLACE, OP_REMOVE: begin
            if ({1'b0, pos_q} < len_q) begin
              state_d = S_READ;
            end else begin
              err_d = ERR_RANGE;
            end
          end
          OP_POP, OP_TAIL: begin
            if (len_q != '0) begin
              pos_d   = ADDR_W'(len_q - 1'b1);
              raddr   = ADDR_W'(len_q - 1'b1);
              state_d = S_READ;
            end else begin
              rnan_d = 1'b1;
            end
          end
          OP_TRUNC: begin
            if (nl_q < len_q) begin
              len_d = nl_q;
            end
          end
          OP_COUNT: rcnt_d = n_q;
          OP_SUM, OP_MEAN, OP_POPVAR, OP_SMPVAR, OP_POPSTD, OP_SMPSTD: begin
            if (n_q == '0) begin
              err_d = ERR_EMPTY;
            end else if ((op_q == OP_SMPVAR || op_q == OP_SMPSTD) && n_q == LEN_W'(1)) begin
              err_d = ERR_SINGLE;
            end else begin
              rdc_d   = '0;
              sum_d   = '0;
              state_d = S_SUM;
            end
          end
          default: ;
        endcase
      end
      S_READ: begin
        res_d   = {{32{rdata[31]}}, rdata};
        state_d = S_DONE;
        case (op_q)
          OP_REPLACE: begin
            we    = 1'b1;
            err_d = nan_q ? ERR_NAN : ERR_NONE;
          end
          OP_POP: len_d = len_q - 1'b1;
          OP_REMOVE: begin
            if ({1'b0, pos_q} + 1'b1 < len_q) begin
              idx_d   = {1'b0, pos_q};
              ins_d   = 1'b0;
              state_d = S_SH_RD;
            end else begin
              len_d = len_q - 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_SH_RD: begin
        raddr   = ins_q ? ADDR_W'(idx_q - 1'b1) : ADDR_W'(idx_q + 1'b1);
        state_d = S_SH_WR;
      end
      S_SH_WR: begin
        we    = 1'b1;
        waddr = idx_q[ADDR_W-1:0];
        wdata = rdata;
        if (ins_q) begin
          idx_d   = idx_q - 1'b1;
          state_d = (idx_q - 1'b1 > {1'b0, pos_q}) ? S_SH_RD : S_INS_WR;
        end else begin
          idx_d = idx_q + 1'b1;
          if (idx_q + LEN_W'(2) < len_q) begin
            state_d = S_SH_RD;
          end else begin
            len_d   = len_q - 1'b1;
            state_d = S_DONE;
          end
        end
      end
      S_INS_WR: begin
        we      = 1'b1;
        len_d   = len_q + 1'b1;
        res_d   = {{32{val_q[31]}}, val_q};
        err_d   = nan_q ? ERR_NAN : ERR_NONE;
        state_d = S_DONE;
      end
      S_SUM: begin
        raddr = rd_addr[ADDR_W-1:0];
        if (rdc_q < n_q) begin
          rdc_d = rdc_q + 1'b1;
          v1_d  = 1'b1;
        end
        if (v1_q) begin
          sum_d = sum_q + $signed({{11{rdata[31]}}, rdata});
        end
        if (rdc_q == n_q && !v1_q) begin
          if (op_q == OP_SUM) begin
            res_d   = {{21{sum_q[42]}}, sum_q};
            state_d = S_DONE;
          end else begin
            neg_d   = sum_q[42];
            dq_d    = {21'd0, sum_abs};
            rem_d   = '0;
            dvs_d   = n_q;
            cnt_d   = '0;
            mph_d   = 1'b1;
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        // Restoring division, one quotient bit per cycle.
        dq_d  = dq_nx;
        rem_d = div_ge ? (ADDR_W+1)'(div_t - {1'b0, dvs_q}) : div_t[ADDR_W:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 6'd63) begin
          if (mph_q) begin
            if (op_q == OP_MEAN) begin
              res_d   = q_abs;
              state_d = S_DONE;
            end else begin
              mean_d  = q_abs[32:0];
              rdc_d   = '0;
              acc_d   = '0;
              state_d = S_DEV;
            end
          end else if (op_q == OP_POPVAR || op_q == OP_SMPVAR) begin
            res_d   = dq_nx;
            state_d = S_DONE;
          end else begin
            big_d   = dq_nx[63:48] != 16'd0;
            sx_d    = (dq_nx[63:48] != 16'd0) ? dq_nx : {dq_nx[47:0], 16'd0};
            sr_d    = '0;
            sb_d    = 64'd1 << 62;
            state_d = S_SQRT;
          end
        end
      end
      S_DEV: begin
        raddr = rd_addr[ADDR_W-1:0];
        if (rdc_q < n_q) begin
          rdc_d = rdc_q + 1'b1;
          v1_d  = 1'b1;
        end
        v2_d = v1_q;
        if (v1_q) begin
          sq_d = dev_abs * dev_abs;
        end
        if (v2_q) begin
          acc_d = acc_q + {10'd0, sq_q};
        end
        if (rdc_q == n_q && !v1_q && !v2_q) begin
          dq_d    = {4'd0, acc_q[75:16]};
          rem_d   = '0;
          dvs_d   = (op_q == OP_POPVAR || op_q == OP_POPSTD) ? n_q : n_q - 1'b1;
          cnt_d   = '0;
          mph_d   = 1'b0;
          neg_d   = 1'b0;
          state_d = S_DIV;
        end
      end
      S_SQRT: begin
        if (sq_ge) begin
          sx_d = sx_q - sq_sum;
        end
        sr_d = sr_nx;
        sb_d = sb_q >> 2;
        if (sb_q == 64'd1) begin
          res_d   = big_q ? (sr_nx << 8) : sr_nx;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!ov_q || out_ready_i) begin
          load_out = 1'b1;
          ov_d     = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  `ASSERT_RST(a_len_cap, len_q <= LEN_W'(CAPACITY), "stored length above capacity")
  `ASSERT_RST(a_nan_result, (out_valid_o && result_is_nan_o) |-> (result_value_o == 64'd0 && error_code_o == ERR_NONE), "NaN result carries a value or error")
  `ASSERT_RST(a_shift_idx, (state_q == S_SH_WR) |-> (idx_q < LEN_W'(CAPACITY)), "shift index outside the store")
  `ASSERT_RST(a_div_idle, (state_q == S_IDLE) |-> (!v1_q && !v2_q), "read pipeline busy while idle")
endmodule
`default_nettype wire

### rtl/slst_ram.sv
`default_nettype none
module slst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import slst_pkg::*;

  localparam int unsigned CAP = slst_pkg::CAPACITY;
  localparam logic [3:0] OP_UNUSED = 4'd15;
  localparam longint INT64_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int HOLD_CYCLES = 2500;
  localparam int RANDOM_ITEMS = 244;

  typedef struct packed {
    logic [3:0]         op;
    logic [9:0]         pos;
    logic               at_end;
    logic signed [31:0] value;
    logic               nan;
    logic [10:0]        skip;
    logic [10:0]        maxc;
    logic [10:0]        newlen;
  } list_cmd_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic               is_nan;
    logic [10:0]        rcount;
    logic [2:0]         err;
  } list_res_t;

  typedef struct packed {
    list_cmd_t cmd;
    logic      typed;
    list_res_t res;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [3:0] operation_i = '0;
  logic [9:0] position_i = '0;
  logic append_at_end_i = 1'b0;
  logic signed [31:0] sample_value_i = '0;
  logic value_is_nan_i = 1'b0;
  logic [LEN_W-1:0] skip_count_i = '0;
  logic [LEN_W-1:0] max_count_i = '0;
  logic [LEN_W-1:0] new_length_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [63:0] result_value_o;
  logic result_is_nan_o;
  logic [LEN_W-1:0] range_count_o;
  logic [2:0] error_code_o;

  sample_list_statistics_top dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .operation_i, .position_i,
    .append_at_end_i, .sample_value_i, .value_is_nan_i, .skip_count_i,
    .max_count_i, .new_length_i, .out_valid_o, .out_ready_i, .result_value_o,
    .result_is_nan_o, .range_count_o, .error_code_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the list, updated as each command transfer is accepted.
  int          shadow_list [CAP];
  int unsigned list_len = 0;
  list_res_t   expected_results [$];
  dir_row_t    directed_rows [$];
  int          fail_count = 0;
  int          cycle_count = 0;
  bit          hold_outputs = 1'b0;
  int          burst_left = 0;

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint span_sum(int unsigned first, int unsigned n);
    longint acc;
    acc = 0;
    for (int unsigned i = 0; i < n; i++) acc += longint'(shadow_list[first + i]);
    return acc;
  endfunction

  function automatic logic [63:0] span_variance(int unsigned first, int unsigned n,
                                                int unsigned divisor);
    longint       avg;
    longint       d;
    logic [63:0]  ad;
    logic [63:0]  sq;
    logic [127:0] acc;
    logic [127:0] scaled;
    logic [63:0]  q;
    avg = span_sum(first, n) / longint'(n);
    acc = '0;
    for (int unsigned i = 0; i < n; i++) begin
      d = longint'(shadow_list[first + i]) - avg;
      ad = (d < 0) ? -d : d;
      sq = ad * ad;
      acc = acc + {64'd0, sq};
    end
    scaled = acc >> 16;
    if (scaled[127:64] != 0) return INT64_MAX;
    q = scaled[63:0] / 64'(divisor);
    if (q > INT64_MAX) q = INT64_MAX;
    return q;
  endfunction

  function automatic list_res_t apply_list_cmd(list_cmd_t c);
    list_res_t r;
    int v;
    int unsigned first;
    int unsigned n;
    int unsigned avail;
    logic [63:0] var_q;
    r = '0;
    v = c.nan ? 0 : c.value;
    first = (c.skip < list_len) ? c.skip : list_len;
    avail = list_len - first;
    n = (c.maxc < avail) ? c.maxc : avail;
    case (c.op)
      OP_APPEND, OP_INSERT: begin
        if (c.nan) r.err = ERR_NAN;
        if (c.op == OP_APPEND || c.at_end || list_len == 0) begin
          if (c.op == OP_INSERT && !c.at_end && c.pos > list_len) begin
            r.err = ERR_RANGE;
          end else if (list_len >= CAP) begin
            r.err = ERR_FULL;
          end else begin
            // Appending through insert drops the nan error; plain append keeps it.
            if (c.op == OP_INSERT) r.err = ERR_NONE;
            shadow_list[list_len] = v;
            list_len++;
            r.value = longint'(v);
          end
        end else if (c.pos > list_len) begin
          r.err = ERR_RANGE;
        end else if (list_len >= CAP) begin
          r.err = ERR_FULL;
        end else begin
          for (int unsigned i = list_len; i > c.pos; i--) shadow_list[i] = shadow_list[i - 1];
          shadow_list[c.pos] = v;
          list_len++;
          r.value = longint'(v);
        end
      end
      OP_GET: begin
        if (c.pos < list_len) r.value = longint'(shadow_list[c.pos]);
        else r.err = ERR_RANGE;
      end
      OP_REPLACE: begin
        if (c.nan) r.err = ERR_NAN;
        if (c.pos < list_len) begin
          r.value = longint'(shadow_list[c.pos]);
          shadow_list[c.pos] = v;
        end else begin
          r.err = ERR_RANGE;
        end
      end
      OP_REMOVE, OP_POP: begin
        if (c.op == OP_POP && list_len == 0) begin
          r.is_nan = 1'b1;
        end else if (c.op == OP_REMOVE && c.pos >= list_len) begin
          r.err = ERR_RANGE;
        end else begin
          first = (c.op == OP_POP) ? list_len - 1 : c.pos;
          r.value = longint'(shadow_list[first]);
          list_len--;
          for (int unsigned i = first; i < list_len; i++) shadow_list[i] = shadow_list[i + 1];
          shadow_list[list_len] = 0;
        end
      end
      OP_TAIL: begin
        if (list_len != 0) r.value = longint'(shadow_list[list_len - 1]);
        else r.is_nan = 1'b1;
      end
      OP_TRUNC: begin
        if (c.newlen < list_len) begin
          for (int unsigned i = c.newlen; i < list_len; i++) shadow_list[i] = 0;
          list_len = c.newlen;
        end
      end
      OP_COUNT: r.rcount = 11'(n);
      OP_SUM, OP_MEAN, OP_POPVAR, OP_SMPVAR, OP_POPSTD, OP_SMPSTD: begin
        if (n == 0) begin
          r.err = ERR_EMPTY;
        end else if (c.op == OP_SUM) begin
          r.value = span_sum(first, n);
        end else if (c.op == OP_MEAN) begin
          r.value = span_sum(first, n) / longint'(n);
        end else if ((c.op == OP_SMPVAR || c.op == OP_SMPSTD) && n == 1) begin
          r.err = ERR_SINGLE;
        end else begin
          var_q = span_variance(first, n,
                                (c.op == OP_POPVAR || c.op == OP_POPSTD) ? n : n - 1);
          if (c.op == OP_POPSTD || c.op == OP_SMPSTD) begin
            if (var_q < (64'd1 << 48)) var_q = int_sqrt(var_q << 16);
            else var_q = int_sqrt(var_q) << 8;
          end
          r.value = var_q;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic list_cmd_t mk_cmd(logic [3:0] op, int pos, bit at_end, int value,
                                       bit nan, int skip, int maxc, int newlen);
    list_cmd_t c;
    c.op = op;
    c.pos = 10'(pos);
    c.at_end = at_end;
    c.value = value;
    c.nan = nan;
    c.skip = 11'(skip);
    c.maxc = 11'(maxc);
    c.newlen = 11'(newlen);
    return c;
  endfunction

  function automatic void add_row(list_cmd_t c, bit typed, longint value = 0,
                                  bit is_nan = 0, int rcount = 0, logic [2:0] err = ERR_NONE);
    dir_row_t row;
    row.cmd = c;
    row.typed = typed;
    row.res.value = value;
    row.res.is_nan = is_nan;
    row.res.rcount = 11'(rcount);
    row.res.err = err;
    directed_rows.push_back(row);
  endfunction

  function automatic int pick_sample();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_count(int unsigned limit);
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 2047);
    return $urandom_range(0, limit);
  endfunction

  function automatic list_cmd_t random_cmd();
    list_cmd_t c;
    int sel;
    c = mk_cmd(OP_APPEND, 0, $urandom_range(0, 3) == 0, pick_sample(),
               $urandom_range(0, 9) == 0, pick_count(list_len), pick_count(list_len + 2),
               pick_count(list_len + 2));
    c.pos = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023))
                                        : 10'($urandom_range(0, list_len + 1));
    sel = $urandom_range(0, 99);
    if (list_len > 48 && $urandom_range(0, 3) == 0) begin
      c.op = OP_TRUNC;
      c.newlen = 11'($urandom_range(0, 16));
    end else if (sel < 25) c.op = OP_APPEND;
    else if (sel < 40) c.op = OP_INSERT;
    else if (sel < 48) c.op = OP_GET;
    else if (sel < 55) c.op = OP_REPLACE;
    else if (sel < 62) c.op = OP_REMOVE;
    else if (sel < 66) c.op = OP_POP;
    else if (sel < 69) c.op = OP_TAIL;
    else if (sel < 73) c.op = OP_TRUNC;
    else if (sel < 77) c.op = OP_COUNT;
    else if (sel < 99) c.op = 4'($urandom_range(OP_SUM, OP_SMPSTD));
    else c.op = OP_UNUSED;
    return c;
  endfunction

  // Drives one command and returns once its transfer has been accepted.
  task automatic send_cmd(list_cmd_t c, bit typed = 0, list_res_t typed_res = '0);
    int gap;
    list_res_t r;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    operation_i <= c.op;
    position_i <= c.pos;
    append_at_end_i <= c.at_end;
    sample_value_i <= c.value;
    value_is_nan_i <= c.nan;
    skip_count_i <= c.skip;
    max_count_i <= c.maxc;
    new_length_i <= c.newlen;
    do @(posedge clk_i); while (!in_ready_o);
    r = apply_list_cmd(c);
    expected_results.push_back(typed ? typed_res : r);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sample_list_statistics_top verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    list_res_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result transfer with nothing expected, value %0d", $time,
                 result_value_o);
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (result_value_o !== exp_r.value) begin
          $display("%0t: result_value expected %0d actual %0d", $time, exp_r.value,
                   result_value_o);
          fail_count++;
        end
        if (result_is_nan_o !== exp_r.is_nan) begin
          $display("%0t: result_is_nan expected %0b actual %0b", $time, exp_r.is_nan,
                   result_is_nan_o);
          fail_count++;
        end
        if (range_count_o !== exp_r.rcount) begin
          $display("%0t: range_count expected %0d actual %0d", $time, exp_r.rcount,
                   range_count_o);
          fail_count++;
        end
        if (error_code_o !== exp_r.err) begin
          $display("%0t: error_code expected %0d actual %0d", $time, exp_r.err,
                   error_code_o);
          fail_count++;
        end
      end
    end
  end

  // Receiver: stretches of free flow, random stalls and full stops, plus one long hold.
  initial begin
    int mode;
    int stretch;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_outputs) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_outputs = 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        stretch = $urandom_range(1, 40);
        repeat (stretch) begin
          case (mode)
            0: out_ready_i <= 1'b1;
            1: out_ready_i <= 1'($urandom_range(0, 1));
            2: out_ready_i <= ($urandom_range(0, 3) == 0);
            default: out_ready_i <= 1'b0;
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    list_cmd_t c;
    // Empty list behavior.
    add_row(mk_cmd(OP_POP, 0, 0, 0, 0, 0, 0, 0), 1, 0, 1);
    add_row(mk_cmd(OP_TAIL, 0, 0, 0, 0, 0, 0, 0), 1, 0, 1);
    add_row(mk_cmd(OP_GET, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0, 0, ERR_RANGE);
    add_row(mk_cmd(OP_SUM, 0, 0, 0, 0, 0, 1024, 0), 1, 0, 0, 0, ERR_EMPTY);
    add_row(mk_cmd(OP_POPSTD, 0, 0, 0, 0, 0, 2047, 0), 1, 0, 0, 0, ERR_EMPTY);
    add_row(mk_cmd(OP_COUNT, 0, 0, 0, 0, 0, 1024, 0), 1, 0, 0, 0, ERR_NONE);
    add_row(mk_cmd(OP_INSERT, 5, 0, 7, 0, 0, 0, 0), 1, 0, 0, 0, ERR_RANGE);
    // Extremes, nan input and single-sample ranges.
    add_row(mk_cmd(OP_APPEND, 0, 0, 32'h7fff_ffff, 0, 0, 0, 0), 1, 64'h7fff_ffff);
    add_row(mk_cmd(OP_SMPVAR, 0, 0, 0, 0, 0, 1, 0), 1, 0, 0, 0, ERR_SINGLE);
    add_row(mk_cmd(OP_SMPSTD, 0, 0, 0, 0, 0, 1, 0), 1, 0, 0, 0, ERR_SINGLE);
    add_row(mk_cmd(OP_APPEND, 0, 0, 32'h8000_0000, 0, 0, 0, 0), 1, -64'sd2147483648);
    add_row(mk_cmd(OP_APPEND, 0, 0, 123, 1, 0, 0, 0), 1, 0, 0, 0, ERR_NAN);
    add_row(mk_cmd(OP_INSERT, 0, 1, 55, 1, 0, 0, 0), 1, 0, 0, 0, ERR_NONE);
    add_row(mk_cmd(OP_INSERT, 0, 0, 32'h0001_0000, 0, 0, 0, 0), 0);
    add_row(mk_cmd(OP_INSERT, 2, 0, 99, 1, 0, 0, 0), 0);
    add_row(mk_cmd(OP_REPLACE, 1, 0, 77, 1, 0, 0, 0), 0);
    add_row(mk_cmd(OP_REMOVE, 3, 0, 0, 0, 0, 0, 0), 0);
    add_row(mk_cmd(OP_GET, 1023, 0, 0, 0, 0, 0, 0), 1, 0, 0, 0, ERR_RANGE);
    add_row(mk_cmd(OP_SUM, 0, 0, 0, 0, 0, 2047, 0), 0);
    add_row(mk_cmd(OP_MEAN, 0, 0, 0, 0, 1, 2047, 0), 0);
    add_row(mk_cmd(OP_POPVAR, 0, 0, 0, 0, 0, 2047, 0), 0);
    add_row(mk_cmd(OP_SMPSTD, 0, 0, 0, 0, 0, 2047, 0), 0);
    add_row(mk_cmd(OP_COUNT, 0, 0, 0, 0, 2047, 2047, 0), 1, 0, 0, 0, ERR_NONE);
    add_row(mk_cmd(OP_UNUSED, 1023, 1, -1, 1, 2047, 2047, 2047), 1, 0, 0, 0, ERR_NONE);
    add_row(mk_cmd(OP_TRUNC, 0, 0, 0, 0, 0, 0, 2047), 0);
    add_row(mk_cmd(OP_TRUNC, 0, 0, 0, 0, 0, 0, 1), 0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) send_cmd(directed_rows[i].cmd, directed_rows[i].typed,
                                        directed_rows[i].res);
    drain_results();

    // Long output hold while commands keep coming, so the input side backs up.
    hold_outputs = 1'b1;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) drain_results();
      c = random_cmd();
      send_cmd(c);
    end
    drain_results();
    repeat (50) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("sample_list_statistics_top verification clean");
    end else begin
      $display("sample_list_statistics_top verification failed");
    end
    $finish;
  end
endmodule
